// ===== design/cbt_pkg.sv =====
// ============================================================================
// CAN bit timing calculator - shared definitions
// Field widths, limits, reset values and the serial divider's word types.
// ============================================================================
package cbt_pkg;

  // Field widths
  localparam int CLK_W   = 28;  // peripheral clock in Hz
  localparam int RATE_W  = 24;  // bit rate in bit/s
  localparam int PROD_W  = 12;  // clock / rate, rate of at least 125000
  localparam int SUM_W   = 5;   // quanta count of the two segments
  localparam int PRE_W   = 11;  // prescaler as reported
  localparam int SEG1_W  = 5;
  localparam int SEG2_W  = 4;

  // Serial divider: one quotient bit per cycle over the whole dividend
  localparam int DIV_STEPS = CLK_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Reset values and rate limits
  localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(36000000);
  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(125000);
  localparam logic [RATE_W-1:0] MIN_RATE    = RATE_W'(125000);
  localparam logic [RATE_W-1:0] MAX_RATE    = RATE_W'(1000000);
  localparam logic [RATE_W-1:0] FAST_RATE   = RATE_W'(1000000);

  // Timing limits
  localparam int MAX_SEG_ONE   = 16;
  localparam int MAX_SEG_TWO   = 8;
  localparam int MAX_PRESCALER = 1024;

  // Segment quanta at which the search starts and ends
  localparam logic [SUM_W-1:0] SUM_SLOW = SUM_W'(16);
  localparam logic [SUM_W-1:0] SUM_FAST = SUM_W'(9);
  localparam logic [SUM_W-1:0] SUM_LAST = SUM_W'(2);

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [CLK_W-1:0]  quotient;
    logic [RATE_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/cbt_ifs.sv =====
// ============================================================================
// CAN bit timing calculator - channel interfaces
// Valid/ready channels for configuration, requests and results.
// ============================================================================

// Configuration write: peripheral clock frequency
interface cbt_cfg_if;
  import cbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] clock_rate;

  modport source (output valid, output clock_rate, input ready);
  modport sink (input valid, input clock_rate, output ready);
endinterface

// Request word: nominal bit rate and flexible data rate flag
interface cbt_req_if;
  import cbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] requested_rate;
  logic              fd_request;

  modport source (output valid, output requested_rate, output fd_request, input ready);
  modport sink (input valid, input requested_rate, input fd_request, output ready);
endinterface

// Result word: timing solution and rate in effect
interface cbt_rsp_if;
  import cbt_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [PRE_W-1:0]  prescaler;
  logic [SEG1_W-1:0] seg_one;
  logic [SEG2_W-1:0] seg_two;
  logic              jump_width;
  logic [RATE_W-1:0] current_rate;

  modport source (output valid, output accepted, output prescaler, output seg_one,
                  output seg_two, output jump_width, output current_rate, input ready);
  modport sink (input valid, input accepted, input prescaler, input seg_one,
                input seg_two, input jump_width, input current_rate, output ready);
endinterface

// ===== design/cbt_div.sv =====
// ============================================================================
// CAN bit timing calculator - serial divider
// Restoring division, one quotient bit per cycle, quotient and remainder.
// ============================================================================
module cbt_div (
  input  logic              clk,
  input  logic              rst,
  input  cbt_pkg::div_req_t req,
  output cbt_pkg::div_rsp_t rsp
);
  import cbt_pkg::*;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [CLK_W-1:0]  quo;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] den;
  logic [RATE_W:0]   part;
  logic [RATE_W+1:0] diff;

  // Bring down the next dividend bit and trial-subtract
  assign part = {rem, quo[CLK_W-1]};
  assign diff = {1'b0, part} - {2'b00, den};

  // Step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_STEPS);
      end
    end
  end

  // Shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      quo <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      if (!diff[RATE_W+1]) begin
        rem <= diff[RATE_W-1:0];
        quo <= {quo[CLK_W-2:0], 1'b1};
      end else begin
        rem <= part[RATE_W-1:0];
        quo <= {quo[CLK_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== design/can_bit_timing_calculator.sv =====
// ============================================================================
// CAN bit timing calculator
// Turns a requested nominal bit rate into prescaler and segment quanta.
// ============================================================================
// Channels: cfg writes the peripheral clock frequency (always ready; write
// it only while no request is in flight). req carries one word per request
// (bit rate, flexible data rate flag); rsp returns one result word for each.
// A flexible data rate request, or a rate outside 125000..1000000, is
// answered without a division. Any other request runs through one shared
// bit-serial divider: clock / rate, then product / (quanta + 1) for each
// quanta count tried (n = 1..15), then, if prescaler and segments are in
// limits, clock / product to check that the quotient equals the rate;
// only one request is in work at a time.
// req.ready is high while no request is in work, and a new request may be
// taken while the previous result still waits in the rsp register.
// If the receiver stalls, the result holds in that register and a finished
// calculation waits until it is free.
// Reset: clock frequency 36000000 Hz, current rate 125000, no result held.
// ============================================================================
module can_bit_timing_calculator (
  input logic        clk,
  input logic        rst,
  cbt_cfg_if.sink    cfg,
  cbt_req_if.sink    req,
  cbt_rsp_if.source  rsp
);
  import cbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT,
    S_MOD,
    S_SEG,
    S_CHECK,
    S_FINISH
  } state_t;

  // Sample point split: 7/8 with rounding, truncation above 900 permill
  localparam logic [7:0]  SP_NUM     = 8'd7;
  localparam logic [7:0]  SP_ROUND   = 8'd3;
  localparam logic [14:0] PERMILL    = 15'd1000;
  localparam logic [14:0] PERMILL_HI = 15'd901;
  localparam logic [PROD_W-1:0] PRE_LIMIT  = PROD_W'(MAX_PRESCALER);
  localparam logic [SUM_W-1:0]  SEG1_LIMIT = SUM_W'(MAX_SEG_ONE);
  localparam logic [SUM_W-1:0]  SEG2_LIMIT = SUM_W'(MAX_SEG_TWO);

  function automatic logic [SUM_W-1:0] seg_one_of(input logic [SUM_W-1:0] s);
    logic [7:0]  s7;
    logic [7:0]  r;
    logic [14:0] lhs;
    logic [14:0] rhs;
    s7  = {3'b000, s} * SP_NUM;
    r   = (s7 + SP_ROUND) >> 3;
    lhs = ({7'b0, r} + 15'd1) * PERMILL;
    rhs = ({10'b0, s} + 15'd1) * PERMILL_HI;
    if (lhs >= rhs) begin
      r = (s7 - 8'd1) >> 3;
    end
    return r[SUM_W-1:0];
  endfunction

  state_t            state;
  logic [CLK_W-1:0]  clock_rate;
  logic [RATE_W-1:0] active_rate;
  logic [RATE_W-1:0] rate;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] pre;
  logic [SUM_W-1:0]  sum;
  logic              ok;
  logic              div_go;
  logic [CLK_W-1:0]  div_num;
  logic [RATE_W-1:0] div_den;
  logic              out_valid;
  logic              out_accepted;
  logic [PRE_W-1:0]  out_prescaler;
  logic [SEG1_W-1:0] out_seg_one;
  logic [SEG2_W-1:0] out_seg_two;
  logic              out_jump_width;
  logic [RATE_W-1:0] out_current_rate;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [SUM_W-1:0]  one_val;
  logic [SUM_W-1:0]  two_val;
  logic              seg_ok;
  logic              rate_ok;

  // Shared serial divider
  assign div_req.start    = div_go;
  assign div_req.dividend = div_num;
  assign div_req.divisor  = div_den;

  cbt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Segment split for the quanta count found
  assign one_val = seg_one_of(sum);
  assign two_val = sum - one_val;
  assign seg_ok  = (one_val != '0) && (one_val <= SEG1_LIMIT) &&
                   (two_val != '0) && (two_val <= SEG2_LIMIT);

  assign rate_ok = !req.fd_request && (req.requested_rate >= MIN_RATE) &&
                   (req.requested_rate <= MAX_RATE);

  // Clock frequency register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_rate <= CLOCK_RESET;
    end else if (cfg.valid) begin
      clock_rate <= cfg.clock_rate;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      div_go      <= 1'b0;
      out_valid   <= 1'b0;
      active_rate <= RATE_RESET;
      ok          <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (out_valid && rsp.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            rate <= req.requested_rate;
            ok   <= 1'b0;
            if (rate_ok) begin
              div_num <= clock_rate;
              div_den <= req.requested_rate;
              div_go  <= 1'b1;
              state   <= S_QUOT;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_QUOT: begin
          // Product of prescaler and quanta per bit
          if (div_rsp.done) begin
            product <= div_rsp.quotient[PROD_W-1:0];
            div_num <= CLK_W'(div_rsp.quotient[PROD_W-1:0]);
            div_go  <= 1'b1;
            if (rate >= FAST_RATE) begin
              sum     <= SUM_FAST;
              div_den <= RATE_W'(SUM_FAST) + RATE_W'(1);
            end else begin
              sum     <= SUM_SLOW;
              div_den <= RATE_W'(SUM_SLOW) + RATE_W'(1);
            end
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // Search downward for an exact divisor
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) begin
              pre   <= div_rsp.quotient[PROD_W-1:0];
              state <= S_SEG;
            end else if (sum <= SUM_LAST) begin
              state <= S_FINISH;
            end else begin
              sum     <= sum - SUM_W'(1);
              div_den <= RATE_W'(sum);
              div_go  <= 1'b1;
            end
          end
        end
        S_SEG: begin
          // Check limits, then check that clock / product gives the rate
          if ((pre != '0) && (pre <= PRE_LIMIT) && seg_ok) begin
            div_num <= clock_rate;
            div_den <= RATE_W'(product);
            div_go  <= 1'b1;
            state   <= S_CHECK;
          end else begin
            state <= S_FINISH;
          end
        end
        S_CHECK: begin
          if (div_rsp.done) begin
            ok    <= (div_rsp.quotient == CLK_W'(rate));
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold until the result register is free
          if (!out_valid || rsp.ready) begin
            out_valid      <= 1'b1;
            out_accepted   <= ok;
            out_prescaler  <= ok ? pre[PRE_W-1:0] : '0;
            out_seg_one    <= ok ? one_val[SEG1_W-1:0] : '0;
            out_seg_two    <= ok ? two_val[SEG2_W-1:0] : '0;
            out_jump_width <= ok;
            out_current_rate <= ok ? rate : active_rate;
            if (ok) begin
              active_rate <= rate;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.accepted     = out_accepted;
  assign rsp.prescaler    = out_prescaler;
  assign rsp.seg_one      = out_seg_one;
  assign rsp.seg_two      = out_seg_two;
  assign rsp.jump_width   = out_jump_width;
  assign rsp.current_rate = out_current_rate;

  // Divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Accepted result carries a full timing solution
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.accepted |-> (rsp.prescaler != '0) && (rsp.seg_one != '0) &&
      (rsp.seg_two != '0) && rsp.jump_width)
    else $error("accepted result with empty timing");

  // Rejected result carries zero timing
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.accepted |-> (rsp.prescaler == '0) && (rsp.seg_one == '0) &&
      (rsp.seg_two == '0) && !rsp.jump_width)
    else $error("rejected result with timing fields set");

  // Held result reports the rate now in effect
  a_rate_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rsp.current_rate == active_rate))
    else $error("reported rate differs from rate in effect");

endmodule
